[design/date_difference_days_macros.svh]
// Assertion macros shared by the date difference design.
`ifndef DATE_DIFFERENCE_DAYS_MACROS_SVH
`define DATE_DIFFERENCE_DAYS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define DDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/ddd_pkg.sv]
// Package: beat types, widths and calendar tables for the date difference block.
`timescale 1ns / 1ps

package ddd_pkg;

    localparam int DAY_W    = 5;
    localparam int MON_W    = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 22;
    localparam int NUM_W    = 23;   // serial day number, holds year 16383
    localparam int QUO_W    = 8;    // year / 100
    localparam int DBM_W    = 9;    // days before a month
    localparam int PROD_W   = 27;   // year times reciprocal of 100

    // floor(x / 100) == (x * 5243) >> 19 for every x below 43699
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [MON_W-1:0] MONTH_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MONTH_DEC = MON_W'(12);

    typedef struct packed {
        logic [DAY_W-1:0]  start_day;
        logic [MON_W-1:0]  start_month;
        logic [YEAR_W-1:0] start_year;
        logic [DAY_W-1:0]  end_day;
        logic [MON_W-1:0]  end_month;
        logic [YEAR_W-1:0] end_year;
        logic              include_end;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               invalid;
    } rsp_t;

    // Converted date handed from a converter to the difference stage
    typedef struct packed {
        logic             ok;
        logic [NUM_W-1:0] num;
    } date_num_t;

    // Length of a month; 0 for a month code that means nothing
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                               len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11:            len = DAY_W'(30);
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            default:                            len = '0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of a month, common year
    function automatic logic [DBM_W-1:0] days_before(input logic [MON_W-1:0] m);
        logic [DBM_W-1:0] n;
        case (m)
            4'd1:    n = DBM_W'(0);
            4'd2:    n = DBM_W'(31);
            4'd3:    n = DBM_W'(59);
            4'd4:    n = DBM_W'(90);
            4'd5:    n = DBM_W'(120);
            4'd6:    n = DBM_W'(151);
            4'd7:    n = DBM_W'(181);
            4'd8:    n = DBM_W'(212);
            4'd9:    n = DBM_W'(243);
            4'd10:   n = DBM_W'(273);
            4'd11:   n = DBM_W'(304);
            4'd12:   n = DBM_W'(334);
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

[design/ddd_date_conv.sv]
// Three-stage converter from a calendar date to a serial day number with a validity flag.
`timescale 1ns / 1ps

module ddd_date_conv
    import ddd_pkg::*;
#(
    parameter int YEAR_LIMIT = 9999
) (
    input  logic              clk,
    input  logic              en,
    input  logic [DAY_W-1:0]  day,
    input  logic [MON_W-1:0]  month,
    input  logic [YEAR_W-1:0] year,
    output date_num_t         res
);

    // Stage 1: year minus one, both quotients by 100, range checks
    logic [DAY_W-1:0]  s1_day_reg;
    logic [MON_W-1:0]  s1_month_reg;
    logic [YEAR_W-1:0] s1_year_reg;
    logic [YEAR_W-1:0] s1_prev_reg;
    logic [QUO_W-1:0]  s1_qy_reg;
    logic [QUO_W-1:0]  s1_qp_reg;
    logic              s1_ym_ok_reg;

    logic [YEAR_W-1:0] s1_prev_next;
    logic [PROD_W-1:0] s1_prod_y;
    logic [PROD_W-1:0] s1_prod_p;
    logic              s1_ym_ok_next;

    always_comb
    begin
        s1_prev_next  = year - YEAR_W'(1);
        s1_prod_y     = PROD_W'(year) * PROD_W'(RECIP_100);
        s1_prod_p     = PROD_W'(s1_prev_next) * PROD_W'(RECIP_100);
        s1_ym_ok_next = (month != '0) && (month <= MONTH_DEC) &&
                        (year != '0) && (int'(year) <= YEAR_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_day_reg   <= day;
            s1_month_reg <= month;
            s1_year_reg  <= year;
            s1_prev_reg  <= s1_prev_next;
            s1_qy_reg    <= s1_prod_y[RECIP_SHIFT +: QUO_W];
            s1_qp_reg    <= s1_prod_p[RECIP_SHIFT +: QUO_W];
            s1_ym_ok_reg <= s1_ym_ok_next;
        end
    end

    // Stage 2: leap year, day check, whole-year part of the day number
    logic [DAY_W-1:0] s2_day_reg;
    logic [MON_W-1:0] s2_month_reg;
    logic             s2_leap_reg;
    logic             s2_ok_reg;
    logic [NUM_W-1:0] s2_base_reg;

    logic [YEAR_W-1:0] s2_rem100;
    logic              s2_leap_next;
    logic              s2_ok_next;
    logic [NUM_W-1:0]  s2_base_next;

    always_comb
    begin
        s2_rem100    = s1_year_reg - YEAR_W'(s1_qy_reg) * YEAR_W'(100);
        s2_leap_next = ((s1_year_reg[1:0] == 2'b00) && (s2_rem100 != '0)) ||
                       ((s2_rem100 == '0) && (s1_qy_reg[1:0] == 2'b00));
        s2_ok_next   = s1_ym_ok_reg && (s1_day_reg != '0) &&
                       (s1_day_reg <= month_len(s1_month_reg, s2_leap_next));
        s2_base_next = NUM_W'(s1_prev_reg) * NUM_W'(365)
                     + NUM_W'(s1_prev_reg[YEAR_W-1:2])
                     - NUM_W'(s1_qp_reg)
                     + NUM_W'(s1_qp_reg[QUO_W-1:2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_day_reg   <= s1_day_reg;
            s2_month_reg <= s1_month_reg;
            s2_leap_reg  <= s2_leap_next;
            s2_ok_reg    <= s2_ok_next;
            s2_base_reg  <= s2_base_next;
        end
    end

    // Stage 3: add month offset, leap day and day of month
    date_num_t res_reg;
    date_num_t res_next;

    always_comb
    begin
        res_next.ok  = s2_ok_reg;
        res_next.num = s2_base_reg
                     + NUM_W'(days_before(s2_month_reg))
                     + NUM_W'(s2_leap_reg && (s2_month_reg > MONTH_FEB))
                     + NUM_W'(s2_day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[design/ddd_diff.sv]
// Final stage: difference of two day numbers, include-end adjust, output register.
`timescale 1ns / 1ps

module ddd_diff
    import ddd_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  date_num_t first,
    input  date_num_t second,
    input  logic      inc,
    output rsp_t      rsp
);

    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic [NUM_W-1:0] span;

    // Span is zero unless start is before end; an invalid date zeroes the day count and sets invalid
    always_comb
    begin
        span = (first.num < second.num) ? (second.num - first.num) : '0;
        rsp_next.invalid = !(first.ok && second.ok);
        if (first.ok && second.ok)
        begin
            rsp_next.day_count = COUNT_W'(span + NUM_W'(inc));
        end
        else
        begin
            rsp_next.day_count = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

[design/date_difference_days.sv]
// Top level: days between two Gregorian dates, four-stage pipeline.
//
// Usage:
//   req channel carries a start date, an end date and include_end in one
//   beat (req_valid / req_ready). rsp channel returns day_count and invalid
//   in one beat (rsp_valid / rsp_ready), one result for every request.
//   The first stage loads at the accepting edge; the beat then passes the
//   other converter stages and the difference stage before rsp_valid rises.
//   One beat is taken every cycle while the output is not held: each stage
//   holds one date pair, the slowest being the quotient-by-100 multiply and
//   the day-number adder chain.
//   If rsp_ready is low while a result waits, the whole pipeline holds and
//   req_ready drops in the same cycle; nothing is lost or repeated.
//   Reset clears all stage valid bits; no result is pending after reset.
//   A date with day past its month, day or month zero, month above 12, or
//   year zero or above YEAR_LIMIT gives invalid = 1 and day_count = 0.
//   A start that is not before the end gives day_count = include_end.
`timescale 1ns / 1ps
`include "date_difference_days_macros.svh"

module date_difference_days
    import ddd_pkg::*;
#(
    parameter int YEAR_LIMIT = 9999
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    localparam int STAGES    = 4;
    localparam int CONV_LAST = STAGES - 2;

    logic [STAGES-1:0]    valid_reg;
    logic [CONV_LAST:0]   inc_reg;
    logic                 en;
    date_num_t            first_num;
    date_num_t            second_num;

    // Pipeline advances unless the output holds an untaken beat
    assign en        = !valid_reg[STAGES-1] || rsp_ready;
    assign req_ready = en;
    assign rsp_valid = valid_reg[STAGES-1];

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], req_valid};
        end
    end

    // include_end rides alongside the converters
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inc_reg <= {inc_reg[CONV_LAST-1:0], req_data.include_end};
        end
    end

    ddd_date_conv #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_conv_start (
        .clk   (clk),
        .en    (en),
        .day   (req_data.start_day),
        .month (req_data.start_month),
        .year  (req_data.start_year),
        .res   (first_num)
    );

    ddd_date_conv #(
        .YEAR_LIMIT (YEAR_LIMIT)
    ) u_conv_end (
        .clk   (clk),
        .en    (en),
        .day   (req_data.end_day),
        .month (req_data.end_month),
        .year  (req_data.end_year),
        .res   (second_num)
    );

    ddd_diff u_diff (
        .clk    (clk),
        .en     (en),
        .first  (first_num),
        .second (second_num),
        .inc    (inc_reg[CONV_LAST]),
        .rsp    (rsp_data)
    );

    // Checks
    `DDD_ASSERT_NOW(a_invalid_zero, clk, rst_n, rsp_valid && rsp_data.invalid, rsp_data.day_count == '0)
    `DDD_ASSERT_NOW(a_stall_blocks, clk, rst_n, rsp_valid && !rsp_ready, !req_ready)
    `DDD_ASSERT_NEXT(a_accept_enters, clk, rst_n, req_valid && req_ready, valid_reg[0])

endmodule
